FILE: src/scsp_pkg.sv
// Shared types and constants for the sound-log command stream parser.
// No dependencies; imported by sound_chip_command_stream_parser_top.
package scsp_pkg;

  // Event codes carried on event_res
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_WRITE   = 3'd1;
  localparam logic [2:0] EV_SEEK    = 3'd2;
  localparam logic [2:0] EV_PERMIT  = 3'd3;
  localparam logic [2:0] EV_WAITING = 3'd4;

  // Command byte codes
  localparam logic [7:0] CMD_ADDR_MAX = 8'hDF;
  localparam logic [7:0] CMD_WAIT1    = 8'hFF;
  localparam logic [7:0] CMD_WAIT16   = 8'hFE;
  localparam logic [7:0] CMD_LOOP     = 8'hFD;

  // Item kinds on func
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [31:0] seek_offset;
    logic [15:0] wait_left;
  } res_t;

endpackage

FILE: src/sound_chip_command_stream_parser_top.sv
// Sound-log command stream parser: byte decode, wait counter, output skid buffer.
// Depends on scsp_pkg.
//
// Takes one word per clock unless stalled: a tick or one command stream byte,
// and returns one result word for each. Each word is decoded combinationally
// from the parse phase and wait counter registers into an output register; a
// one-word skid stage behind it keeps in_ready_o high while a result waits, so
// the input only stalls once two results are held. The user writes loop_offset
// through cfg_we_i/cfg_wdata_i only while the block is idle; not enforced.
module sound_chip_command_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  reg_addr_o,
  output logic [7:0]  reg_data_o,
  output logic [31:0] seek_offset_o,
  output logic [15:0] wait_left_o
);
  import scsp_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_DATA    = 2'd1;
  localparam logic [1:0] PH_WAIT_LO = 2'd2;
  localparam logic [1:0] PH_WAIT_HI = 2'd3;

  logic [31:0] loop_offset_q;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  pend_addr_q, pend_addr_d;
  logic [7:0]  wait_lo_q, wait_lo_d;
  logic [15:0] wait_cnt_q, wait_cnt_d;

  logic        main_valid_q, skid_valid_q;
  res_t        main_q, skid_q, res_d;
  logic        in_fire, out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = main_valid_q && out_ready_i;

  always_comb begin
    phase_d     = phase_q;
    pend_addr_d = pend_addr_q;
    wait_lo_d   = wait_lo_q;
    wait_cnt_d  = wait_cnt_q;
    res_d       = '0;
    res_d.event_res = EV_NONE;
    if (func_i == FUNC_TICK) begin
      if (wait_cnt_q != 16'd0) begin
        wait_cnt_d      = wait_cnt_q - 16'd1;
        res_d.event_res = EV_WAITING;
      end else begin
        res_d.event_res = EV_PERMIT;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (stream_byte_i <= CMD_ADDR_MAX) begin
            pend_addr_d = stream_byte_i;
            phase_d     = PH_DATA;
          end else if (stream_byte_i == CMD_WAIT1) begin
            wait_cnt_d = 16'd1;
          end else if (stream_byte_i == CMD_WAIT16) begin
            phase_d = PH_WAIT_LO;
          end else if (stream_byte_i == CMD_LOOP) begin
            res_d.event_res   = EV_SEEK;
            res_d.seek_offset = loop_offset_q;
          end
        end
        PH_DATA: begin
          res_d.event_res = EV_WRITE;
          res_d.reg_addr  = pend_addr_q;
          res_d.reg_data  = stream_byte_i;
          phase_d         = PH_IDLE;
        end
        PH_WAIT_LO: begin
          wait_lo_d = stream_byte_i;
          phase_d   = PH_WAIT_HI;
        end
        default: begin
          wait_cnt_d = {stream_byte_i, wait_lo_q};
          phase_d    = PH_IDLE;
        end
      endcase
    end
    res_d.wait_left = wait_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_offset_q <= '0;
      phase_q       <= PH_IDLE;
      pend_addr_q   <= '0;
      wait_lo_q     <= '0;
      wait_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        loop_offset_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        pend_addr_q <= pend_addr_d;
        wait_lo_q   <= wait_lo_d;
        wait_cnt_q  <= wait_cnt_d;
      end
    end
  end

  // Output register with one-word skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= res_d;
      end
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = main_valid_q;
  assign event_res_o   = main_q.event_res;
  assign reg_addr_o    = main_q.reg_addr;
  assign reg_data_o    = main_q.reg_data;
  assign seek_offset_o = main_q.seek_offset;
  assign wait_left_o   = main_q.wait_left;

`ifndef NO_ASSERTIONS
  // skid only fills behind a held result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word held with output register empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && main_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("word accepted under stall not kept in skid");

  a_tick_keeps_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func_i == FUNC_TICK) |=> $stable(phase_q))
    else $error("tick changed parse phase");

  a_data_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && func_i == FUNC_BYTE && phase_q == PH_DATA) |=> phase_q == PH_IDLE)
    else $error("data byte did not end register write");
`endif

endmodule

FILE: verif/scsp_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the command stream parser testbench: predicts one result per
// accepted word and checks returned results in order. Depends on scsp_pkg.
package scsp_tb_pkg;
  import scsp_pkg::*;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_DATA,
    PHASE_WAIT_LO,
    PHASE_WAIT_HI
  } parse_phase_e;

  class parse_scoreboard;
    logic [31:0]  loop_offset;
    parse_phase_e phase;
    logic [7:0]   held_addr;
    logic [7:0]   held_wait_lo;
    logic [15:0]  wait_count;
    res_t         expected_results[$];
    int           mismatches;

    function new();
      loop_offset  = '0;
      phase        = PHASE_IDLE;
      held_addr    = '0;
      held_wait_lo = '0;
      wait_count   = '0;
      mismatches   = 0;
    endfunction

    function void set_loop_offset(logic [31:0] value);
      loop_offset = value;
    endfunction

    // Decode one accepted word against the shadow state and queue its result
    function void note_word(logic kind, logic [7:0] b);
      res_t r;
      r = '0;
      r.event_res = EV_NONE;
      if (kind == FUNC_TICK) begin
        if (wait_count != 16'd0) begin
          wait_count  = wait_count - 16'd1;
          r.event_res = EV_WAITING;
        end else begin
          r.event_res = EV_PERMIT;
        end
      end else begin
        case (phase)
          PHASE_IDLE: begin
            if (b <= CMD_ADDR_MAX) begin
              held_addr = b;
              phase     = PHASE_DATA;
            end else if (b == CMD_WAIT1) begin
              wait_count = 16'd1;
            end else if (b == CMD_WAIT16) begin
              phase = PHASE_WAIT_LO;
            end else if (b == CMD_LOOP) begin
              r.event_res   = EV_SEEK;
              r.seek_offset = loop_offset;
            end
          end
          PHASE_DATA: begin
            r.event_res = EV_WRITE;
            r.reg_addr  = held_addr;
            r.reg_data  = b;
            phase       = PHASE_IDLE;
          end
          PHASE_WAIT_LO: begin
            held_wait_lo = b;
            phase        = PHASE_WAIT_HI;
          end
          default: begin
            wait_count = {b, held_wait_lo};
            phase      = PHASE_IDLE;
          end
        endcase
      end
      r.wait_left = wait_count;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (event %0d)", got.event_res));
        return;
      end
      want = expected_results.pop_front();
      if (got.event_res !== want.event_res)
        report_mismatch($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
      if (got.reg_addr !== want.reg_addr)
        report_mismatch($sformatf("reg_addr %h, want %h", got.reg_addr, want.reg_addr));
      if (got.reg_data !== want.reg_data)
        report_mismatch($sformatf("reg_data %h, want %h", got.reg_data, want.reg_data));
      if (got.seek_offset !== want.seek_offset)
        report_mismatch($sformatf("seek_offset %h, want %h",
                                  got.seek_offset, want.seek_offset));
      if (got.wait_left !== want.wait_left)
        report_mismatch($sformatf("wait_left %h, want %h", got.wait_left, want.wait_left));
    endtask
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for sound_chip_command_stream_parser_top: directed words, then
// random command streams under idle gaps and back-pressure.
// Depends on scsp_pkg and scsp_tb_pkg.
module tb_top;
  import scsp_pkg::*;
  import scsp_tb_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_WORDS    = 300;
  localparam int IDLE_PCT       = 38;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        func_i        = FUNC_TICK;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  reg_addr_o;
  logic [7:0]  reg_data_o;
  logic [31:0] seek_offset_o;
  logic [15:0] wait_left_o;

  parse_scoreboard sb = new();

  bit   no_idle      = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_done    = 1'b0;
  int   hold_left    = 0;
  int   words_sent   = 0;
  res_t seen;

  // {func, byte}; tick bytes are junk and must be ignored
  logic [8:0] directed_words [$] = '{
    {FUNC_BYTE, CMD_LOOP},
    {FUNC_TICK, 8'hA5},
    {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'hFF},
    {FUNC_BYTE, CMD_ADDR_MAX}, {FUNC_BYTE, 8'h00},
    {FUNC_BYTE, CMD_LOOP},
    {FUNC_BYTE, 8'hE0}, {FUNC_BYTE, 8'hFC},
    {FUNC_BYTE, CMD_WAIT1}, {FUNC_TICK, 8'hFF}, {FUNC_TICK, 8'h00},
    {FUNC_BYTE, CMD_WAIT16}, {FUNC_BYTE, 8'h00}, {FUNC_BYTE, 8'h00}, {FUNC_TICK, 8'h5A},
    {FUNC_BYTE, CMD_WAIT16}, {FUNC_BYTE, 8'hFF}, {FUNC_BYTE, 8'hFF}, {FUNC_TICK, 8'h3C},
    {FUNC_BYTE, CMD_WAIT1},
    {FUNC_BYTE, CMD_WAIT16}, {FUNC_TICK, 8'hC3}, {FUNC_BYTE, 8'h34},
    {FUNC_TICK, 8'h81}, {FUNC_BYTE, 8'h12}
  };

  sound_chip_command_stream_parser_top DUT (.*);

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Result side: check accepted words, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      seen = '{event_res_o, reg_addr_o, reg_data_o, seek_offset_o, wait_left_o};
      sb.check_result(seen);
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [7:0] b);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= kind;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(kind, b);
    words_sent++;
  endtask

  // Only written once every queued result is back
  task automatic write_loop_offset(input logic [31:0] value);
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_loop_offset(value);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed commands with random content, some stray words
  task automatic send_command();
    int         pick;
    int         ticks;
    logic [7:0] lo;
    logic [7:0] hi;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_word(FUNC_BYTE, 8'($urandom_range(0, CMD_ADDR_MAX)));
      if ($urandom_range(0, 9) == 0) send_word(FUNC_TICK, 8'($urandom()));
      send_word(FUNC_BYTE, 8'($urandom()));
    end else if (pick < 45) begin
      send_word(FUNC_BYTE, CMD_WAIT1);
    end else if (pick < 58) begin
      lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      hi = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'h00;
      send_word(FUNC_BYTE, CMD_WAIT16);
      if ($urandom_range(0, 9) == 0) send_word(FUNC_TICK, 8'($urandom()));
      send_word(FUNC_BYTE, lo);
      if ($urandom_range(0, 9) == 0) send_word(FUNC_TICK, 8'($urandom()));
      send_word(FUNC_BYTE, hi);
    end else if (pick < 65) begin
      send_word(FUNC_BYTE, CMD_LOOP);
    end else if (pick < 70) begin
      send_word(FUNC_BYTE, 8'($urandom_range(CMD_ADDR_MAX + 1, CMD_LOOP - 1)));
    end else if (pick < 90) begin
      ticks = $urandom_range(1, 4);
      repeat (ticks) send_word(FUNC_TICK, 8'($urandom()));
    end else begin
      send_word(1'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] offsets [5];
    int          target;
    offsets = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'h8000_0000, 32'h0000_0001};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first loop command sees the reset offset
    send_word(directed_words[0][8], directed_words[0][7:0]);
    write_loop_offset(32'hDEAD_BEEF);
    for (int i = 1; i < directed_words.size(); i++)
      send_word(directed_words[i][8], directed_words[i][7:0]);

    for (int p = 0; p < 5; p++) begin
      write_loop_offset(offsets[p]);
      if (p == 1) hold_request = 1'b1;
      no_idle = (p == 3);
      target  = words_sent + PHASE_WORDS;
      while (words_sent < target) send_command();
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
